// ===== hw/rtl/fpr_pkg.sv =====
// ----------------------------------------------------------------------------
// fpr_pkg
// shared types, constants and helpers for the passive reply port parser
// ----------------------------------------------------------------------------
`default_nettype none

package fpr_pkg;

	localparam int LANES = 6;

	localparam logic [9:0] PASV_CODE = 10'd227;
	localparam logic [2:0] CODE_POS_LAST = 3'd2;
	localparam logic [2:0] TEXT_POS = 3'd4;

	localparam logic [2:0] FIFTH_IDX = 3'd4;
	localparam logic [2:0] SIXTH_IDX = 3'd5;

	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_PLUS = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_NUL = 8'h00;

	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_DIGITS = 2'd1,
		PH_SEP    = 2'd2,
		PH_SIGN   = 2'd3
	} phase_t;

	// one match attempt
	typedef struct packed {
		phase_t      phase;
		logic [2:0]  idx;
		logic [7:0]  acc;
		logic        neg;
		logic [7:0]  fifth;
	} lane_t;

	localparam lane_t LANE_IDLE = '{
		phase: PH_IDLE, idx: 3'd0, acc: 8'd0, neg: 1'b0, fifth: 8'd0
	};

	// scan outcome after the current byte
	typedef struct packed {
		logic        found;
		logic [15:0] port;
	} scan_res_t;

	function automatic logic is_dig(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic is_ws(input logic [7:0] c);
		return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
	endfunction

	function automatic logic [7:0] digit_of(input logic [7:0] c);
		return 8'(c - CH_ZERO);
	endfunction

	// two's complement of the magnitude when the minus flag is set
	function automatic logic [7:0] lane_value(input lane_t l);
		return l.neg ? 8'(8'd0 - l.acc) : l.acc;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/fpr_lane.sv =====
// ----------------------------------------------------------------------------
// fpr_lane
// next-state logic of one number-list match attempt for one byte
// ----------------------------------------------------------------------------
`default_nettype none

module fpr_lane (
	input  wire fpr_pkg::lane_t cur,
	input  wire logic [7:0]     data,
	output fpr_pkg::lane_t      nxt
);
	import fpr_pkg::*;

	logic       dig;
	logic [7:0] d;

	assign dig = is_dig(data);
	assign d   = digit_of(data);

	always_comb begin
		nxt = cur;
		unique case (cur.phase)
			PH_DIGITS: begin
				if (dig) begin
					nxt.acc = 8'(11'(cur.acc) * 11'd10 + 11'(d));
				end else if (cur.idx == SIXTH_IDX) begin
					// end of sixth number, taken as a match by the scanner
					nxt = cur;
				end else if (data == CH_COMMA) begin
					if (cur.idx == FIFTH_IDX) begin
						nxt.fifth = lane_value(cur);
					end
					nxt.idx   = 3'(cur.idx + 3'd1);
					nxt.phase = PH_SEP;
					nxt.acc   = 8'd0;
					nxt.neg   = 1'b0;
				end else begin
					nxt.phase = PH_IDLE;
				end
			end
			PH_SEP: begin
				if (is_ws(data)) begin
					nxt = cur;
				end else if ((data == CH_PLUS) || (data == CH_MINUS)) begin
					nxt.neg   = (data == CH_MINUS);
					nxt.phase = PH_SIGN;
				end else if (dig) begin
					nxt.acc   = d;
					nxt.phase = PH_DIGITS;
				end else begin
					nxt.phase = PH_IDLE;
				end
			end
			PH_SIGN: begin
				if (dig) begin
					nxt.acc   = d;
					nxt.phase = PH_DIGITS;
				end else begin
					nxt.phase = PH_IDLE;
				end
			end
			PH_IDLE: begin
				nxt = cur;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== hw/rtl/fpr_scan.sv =====
// ----------------------------------------------------------------------------
// fpr_scan
// parallel match attempts over the reply text, lane allocation and result
// ----------------------------------------------------------------------------
`default_nettype none

module fpr_scan (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step,
	input  wire logic              last,
	input  wire logic              scan_en,
	input  wire logic [7:0]        data,
	output fpr_pkg::scan_res_t     res
);
	import fpr_pkg::*;

	lane_t       lane_q     [LANES];
	lane_t       lane_nxt   [LANES];
	lane_t       lane_alloc [LANES];
	logic        prev_dig_q;
	logic        text_end_q;
	logic        done_q;
	logic [15:0] port_q;

	logic        dig;
	logic        zero;
	logic        gate;
	logic        any_hit;
	logic [15:0] hit_port;
	logic        any_fin;
	logic [15:0] fin_port;
	logic        taken;
	logic        match_now;

	for (genvar i = 0; i < LANES; i++) begin : g_lane
		fpr_lane u_lane (
			.cur  (lane_q[i]),
			.data (data),
			.nxt  (lane_nxt[i])
		);
	end

	assign dig  = is_dig(data);
	assign zero = (data == CH_NUL);
	assign gate = scan_en && !text_end_q && !done_q;

	always_comb begin
		any_hit  = 1'b0;
		hit_port = 16'd0;
		any_fin  = 1'b0;
		fin_port = 16'd0;
		taken    = 1'b0;

		// sixth number closed by a non-digit, lowest lane wins
		for (int i = LANES - 1; i >= 0; i--) begin
			if ((lane_q[i].phase == PH_DIGITS) && (lane_q[i].idx == SIXTH_IDX) && !dig) begin
				any_hit  = 1'b1;
				hit_port = {lane_q[i].fifth, lane_value(lane_q[i])};
			end
		end

		// a digit after a non-digit starts a new attempt in the first idle lane
		for (int i = 0; i < LANES; i++) begin
			lane_alloc[i] = lane_nxt[i];
			if (dig && !prev_dig_q && !taken && (lane_nxt[i].phase == PH_IDLE)) begin
				lane_alloc[i] = '{phase: PH_DIGITS, idx: 3'd0, acc: digit_of(data),
					neg: 1'b0, fifth: 8'd0};
				taken = 1'b1;
			end
		end

		// end of line while still inside the sixth number
		for (int i = LANES - 1; i >= 0; i--) begin
			if ((lane_alloc[i].phase == PH_DIGITS) && (lane_alloc[i].idx == SIXTH_IDX)) begin
				any_fin  = 1'b1;
				fin_port = {lane_alloc[i].fifth, lane_value(lane_alloc[i])};
			end
		end

		match_now = gate && (any_hit || (!zero && last && any_fin));
		res.found = done_q || match_now;
		res.port  = match_now ? (any_hit ? hit_port : fin_port) : port_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LANES; i++) begin
				lane_q[i] <= LANE_IDLE;
			end
			prev_dig_q <= 1'b0;
			text_end_q <= 1'b0;
			done_q     <= 1'b0;
			port_q     <= 16'd0;
		end else if (step) begin
			if (last) begin
				for (int i = 0; i < LANES; i++) begin
					lane_q[i] <= LANE_IDLE;
				end
				prev_dig_q <= 1'b0;
				text_end_q <= 1'b0;
				done_q     <= 1'b0;
				port_q     <= 16'd0;
			end else if (gate) begin
				if (zero || any_hit) begin
					for (int i = 0; i < LANES; i++) begin
						lane_q[i] <= LANE_IDLE;
					end
					text_end_q <= zero;
					done_q     <= any_hit;
					port_q     <= any_hit ? hit_port : port_q;
				end else begin
					for (int i = 0; i < LANES; i++) begin
						lane_q[i] <= lane_alloc[i];
					end
					prev_dig_q <= dig;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/ftp_passive_reply_port_parser.sv =====
// ----------------------------------------------------------------------------
// ftp_passive_reply_port_parser
// reads reply line bytes, reports the reply code and the passive data port
// ----------------------------------------------------------------------------
//
// channel   direction  handshake          payload
// s_*       in         s_tvalid/s_tready  s_tdata[7:0] data_byte, s_tlast last_byte
// m_*       out        m_tvalid/m_tready  m_tdata[28:0] reply fields, one per line
//
// one byte per cycle sustained unless a last byte waits on a full, stalled output register;
// the lane state feeds back on itself each byte; a reply sits on m_* once the byte carrying
// s_tlast has passed the input register and been loaded into the output register
// arst_n clears line state, lanes and the valid bits of both registers, no clearing pass
// a stalled reply holds in the output register while the next line's bytes
// keep flowing until another last byte reaches the processing step
//
`default_nettype none

module ftp_passive_reply_port_parser (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output      logic        s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
	input  wire logic        s_tlast,   // last_byte
	output      logic        m_tvalid,
	input  wire logic        m_tready,
	output      logic [31:0] m_tdata    // [0] code_valid, [10:1] reply_code,
	                                    // [11] is_passive, [12] port_found,
	                                    // [28:13] data_port, [31:29] zero
);
	import fpr_pkg::*;

	// input register
	logic        vld_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;

	// line header state
	logic [2:0]  pos_q;
	logic [9:0]  code_q;
	logic        code_ok_q;

	// output register
	logic        out_vld_q;
	logic [31:0] out_data_q;

	logic        adv;
	logic        in_code;
	logic        dig;
	logic [9:0]  code_n;
	logic        code_ok_n;
	logic        code_valid;
	logic        passive;
	logic        scan_en;
	scan_res_t   scan_res;

	// the held byte moves on unless it would emit into a full output register that is not being read
	assign adv      = vld_s1 && (!last_s1 || !out_vld_q || m_tready);
	assign s_tready = !vld_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	// reply code from the first three bytes
	always_comb begin
		in_code   = (pos_q <= CODE_POS_LAST);
		dig       = is_dig(byte_s1);
		code_n    = code_q;
		code_ok_n = code_ok_q;
		if (in_code) begin
			if (dig) begin
				code_n = 10'(14'(code_q) * 14'd10 + 14'(digit_of(byte_s1)));
			end else begin
				code_ok_n = 1'b0;
			end
		end
		code_valid = code_ok_n && (pos_q >= CODE_POS_LAST);
		passive    = code_valid && (code_n == PASV_CODE);
		// text scan starts at the fifth byte
		scan_en    = (pos_q >= TEXT_POS) && passive;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= 3'd0;
			code_q    <= 10'd0;
			code_ok_q <= 1'b1;
		end else if (adv) begin
			if (last_s1) begin
				pos_q     <= 3'd0;
				code_q    <= 10'd0;
				code_ok_q <= 1'b1;
			end else begin
				pos_q     <= (pos_q < TEXT_POS) ? 3'(pos_q + 3'd1) : pos_q;
				code_q    <= code_n;
				code_ok_q <= code_ok_n;
			end
		end
	end

	fpr_scan u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (adv),
		.last    (last_s1),
		.scan_en (scan_en),
		.data    (byte_s1),
		.res     (scan_res)
	);

	// result register, loaded on the last byte of a line
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv && last_s1) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && last_s1) begin
			out_data_q <= {3'b000,
				scan_res.found ? scan_res.port : 16'd0,
				scan_res.found,
				passive,
				code_valid ? code_n : 10'd0,
				code_valid};
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;

endmodule

`default_nettype wire

// ===== hw/rtl/fpr_checker.sv =====
// ----------------------------------------------------------------------------
// fpr_checker
// port-level checks on the reply stream of the passive reply port parser
// ----------------------------------------------------------------------------
`default_nettype none

module fpr_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [31:0] m_tdata
);

	// a stalled reply holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("reply changed while stalled");

	// passive flag only with a valid code of 227
	a_passive: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[11] |-> m_tdata[0] && (m_tdata[10:1] == 10'd227))
		else $error("passive flag without code 227");

	// a port is only found on a passive reply
	a_port: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[12] |-> m_tdata[11])
		else $error("port found on a non-passive reply");

	// unset flags carry zero fields and the pad stays clear
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[0] || (m_tdata[10:1] == 10'd0))
			&& (m_tdata[12] || (m_tdata[28:13] == 16'd0))
			&& (m_tdata[31:29] == 3'd0))
		else $error("reply fields not zero under cleared flags");

endmodule

bind ftp_passive_reply_port_parser fpr_checker u_fpr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the passive reply port parser: reply lines go in
// byte by byte, a local line scanner predicts each reply and every reply
// transaction is checked field by field against the oldest prediction
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
	import fpr_pkg::*;

	localparam int unsigned LIMIT_CYCLES = 300000;
	localparam int unsigned RANDOM_BYTES = 620;
	localparam int unsigned DRAIN_CYCLES = 20;
	localparam int unsigned MAX_REPORTS = 10;
	localparam int unsigned HOLD_AFTER = 25;     // replies seen before the long hold-off
	localparam int unsigned HOLD_CYCLES = 400;
	localparam int unsigned DRAIN_LINE = 12;     // random line that waits for an empty pipe

	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_VT = 8'h0B;
	localparam logic [7:0] CH_FF = 8'h0C;

	typedef enum logic [1:0] {
		PACE_OPEN,
		PACE_LIGHT,
		PACE_HEAVY
	} pace_t;

	// one line byte waiting for the sender
	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       wait_drain;
	} byte_item_t;

	// reply fields, lowest bit last, as they sit in m_tdata[28:0]
	typedef struct packed {
		logic [15:0] data_port;
		logic        port_found;
		logic        is_passive;
		logic [9:0]  reply_code;
		logic        code_valid;
	} pasv_reply_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;

	byte_item_t  queued_bytes [$];
	pasv_reply_t pending_replies [$];
	logic [7:0]  line_buf [$];

	int unsigned bytes_total = 0;
	int unsigned bytes_taken = 0;
	int unsigned replies_seen = 0;
	int unsigned ports_seen = 0;
	int unsigned passive_seen = 0;
	int unsigned mismatch_cnt = 0;
	int unsigned cycle_cnt = 0;
	int unsigned burst_left = 0;
	int unsigned gap_left = 0;
	int unsigned hold_cnt = 0;
	logic        hold_done = 1'b0;
	int unsigned pace_left = 0;
	pace_t       pace_mode = PACE_OPEN;

	// line scanner state
	logic [2:0]  line_pos;
	logic [9:0]  code_val;
	logic        code_ok;
	logic        last_was_digit;
	logic        text_stopped;
	lane_t       scan_lanes [LANES];
	logic        port_locked;
	logic [15:0] port_val;

	ftp_passive_reply_port_parser i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic is_digit_byte(input logic [7:0] c);
		return c inside {[CH_ZERO:CH_NINE]};
	endfunction

	function automatic logic is_blank_byte(input logic [7:0] c);
		return c inside {CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR};
	endfunction

	// signed view of a lane's running value, folded to one byte
	function automatic logic [7:0] lane_low_byte(input lane_t ln);
		return ln.neg ? (~ln.acc + 8'd1) : ln.acc;
	endfunction

	task automatic lanes_clear();
		for (int i = 0; i < LANES; i++) scan_lanes[i] = LANE_IDLE;
	endtask

	task automatic clear_line_model();
		line_pos = 3'd0;
		code_val = 10'd0;
		code_ok = 1'b1;
		last_was_digit = 1'b0;
		text_stopped = 1'b0;
		port_locked = 1'b0;
		port_val = 16'd0;
		lanes_clear();
	endtask

	task automatic port_take(input lane_t ln);
		port_val = {ln.fifth, lane_low_byte(ln)};
		port_locked = 1'b1;
		lanes_clear();
	endtask

	// text is over: the first lane sitting in its sixth number wins
	task automatic lanes_finish();
		logic hit;
		hit = 1'b0;
		for (int i = 0; i < LANES && !hit; i++) begin
			if (scan_lanes[i].phase == PH_DIGITS && scan_lanes[i].idx == SIXTH_IDX) begin
				port_take(scan_lanes[i]);
				hit = 1'b1;
			end
		end
		if (!hit) lanes_clear();
	endtask

	// advances the line scanner by one byte, queues the reply on the last byte
	task automatic parse_reply_byte(input logic [7:0] c, input logic last);
		logic       dig, code_now, passive, stop, placed;
		logic [7:0] dval;
		pasv_reply_t r;
		dig = is_digit_byte(c);
		dval = c - CH_ZERO;
		if (line_pos <= CODE_POS_LAST) begin
			if (dig) code_val = code_val * 10'd10 + 10'(dval);
			else code_ok = 1'b0;
		end
		code_now = code_ok && (line_pos >= CODE_POS_LAST);
		passive = code_now && (code_val == PASV_CODE);
		if (line_pos >= TEXT_POS && passive && !text_stopped && !port_locked) begin
			if (c == CH_NUL) begin
				lanes_finish();
				text_stopped = 1'b1;
			end else begin
				stop = 1'b0;
				for (int i = 0; i < LANES && !stop; i++) begin
					case (scan_lanes[i].phase)
						PH_DIGITS: begin
							if (dig) begin
								scan_lanes[i].acc = scan_lanes[i].acc * 8'd10 + dval;
							end else if (scan_lanes[i].idx == SIXTH_IDX) begin
								port_take(scan_lanes[i]);
								stop = 1'b1;
							end else if (c == CH_COMMA) begin
								if (scan_lanes[i].idx == FIFTH_IDX)
									scan_lanes[i].fifth = lane_low_byte(scan_lanes[i]);
								scan_lanes[i].idx = scan_lanes[i].idx + 3'd1;
								scan_lanes[i].phase = PH_SEP;
								scan_lanes[i].acc = 8'd0;
								scan_lanes[i].neg = 1'b0;
							end else begin
								scan_lanes[i].phase = PH_IDLE;
							end
						end
						PH_SEP: begin
							if (is_blank_byte(c)) begin
								// whitespace before a number is skipped
							end else if (c == CH_PLUS || c == CH_MINUS) begin
								scan_lanes[i].neg = (c == CH_MINUS);
								scan_lanes[i].phase = PH_SIGN;
							end else if (dig) begin
								scan_lanes[i].acc = dval;
								scan_lanes[i].phase = PH_DIGITS;
							end else begin
								scan_lanes[i].phase = PH_IDLE;
							end
						end
						PH_SIGN: begin
							if (dig) begin
								scan_lanes[i].acc = dval;
								scan_lanes[i].phase = PH_DIGITS;
							end else begin
								scan_lanes[i].phase = PH_IDLE;
							end
						end
						default: ;
					endcase
				end
				// a fresh digit run opens a new attempt in the first idle lane
				if (!stop) begin
					if (dig && !last_was_digit) begin
						placed = 1'b0;
						for (int i = 0; i < LANES && !placed; i++) begin
							if (scan_lanes[i].phase == PH_IDLE) begin
								scan_lanes[i] = LANE_IDLE;
								scan_lanes[i].phase = PH_DIGITS;
								scan_lanes[i].acc = dval;
								placed = 1'b1;
							end
						end
					end
					last_was_digit = dig;
				end
				if (last && !port_locked) lanes_finish();
			end
		end
		if (line_pos < TEXT_POS) line_pos = line_pos + 3'd1;
		if (last) begin
			r.code_valid = code_now;
			r.reply_code = code_now ? code_val : 10'd0;
			r.is_passive = passive;
			r.port_found = port_locked;
			r.data_port = port_locked ? port_val : 16'd0;
			pending_replies.push_back(r);
			clear_line_model();
		end
	endtask

	task automatic put_byte(input logic [7:0] b);
		line_buf.push_back(b);
	endtask

	task automatic put_text(input string s);
		for (int k = 0; k < s.len(); k++) line_buf.push_back(s[k]);
	endtask

	// moves the built line into the send queue, last flag on its final byte
	task automatic end_line(input logic drain_first);
		byte_item_t it;
		for (int k = 0; k < line_buf.size(); k++) begin
			it.data = line_buf[k];
			it.last = (k == line_buf.size() - 1);
			it.wait_drain = drain_first && (k == 0);
			queued_bytes.push_back(it);
		end
		bytes_total += line_buf.size();
		line_buf.delete();
	endtask

	// half the time a byte from the number syntax, otherwise any byte
	function automatic logic [7:0] rand_text_byte();
		string glyphs;
		glyphs = "0123456789,+- (";
		if ($urandom_range(0, 1) != 0) return 8'($urandom_range(0, 255));
		return glyphs[$urandom_range(0, glyphs.len() - 1)];
	endfunction

	task automatic check_field(input string what, input logic [15:0] want,
			input logic [15:0] got);
		if (want !== got) begin
			mismatch_cnt++;
			if (mismatch_cnt <= MAX_REPORTS)
				$display("reply %0d, %s: expected %0d, got %0d", replies_seen, what,
					want, got);
		end
	endtask

	// sender: bursts of random length, random gaps, optional wait for empty pipe
	always @(posedge clk or negedge arst_n) begin : byte_sender
		byte_item_t nxt;
		logic offer;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= 8'h00;
			s_tlast <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				parse_reply_byte(s_tdata, s_tlast);
				bytes_taken++;
			end
			if (!s_tvalid || s_tready) begin
				offer = 1'b0;
				if (gap_left > 0) begin
					gap_left--;
				end else if (queued_bytes.size() > 0 &&
						!(queued_bytes[0].wait_drain && pending_replies.size() > 0)) begin
					nxt = queued_bytes.pop_front();
					s_tdata <= nxt.data;
					s_tlast <= nxt.last;
					offer = 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else if ($urandom_range(0, 3) == 0) begin
						burst_left = $urandom_range(20, 60);
						gap_left = 0;
					end else begin
						burst_left = $urandom_range(0, 12);
						gap_left = $urandom_range(1, 6);
					end
				end
				s_tvalid <= offer;
			end
		end
	end

	// receiver: its own stall pattern plus one long hold-off to back up the block
	always @(posedge clk or negedge arst_n) begin : reply_pacer
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_cnt > 0) begin
			hold_cnt--;
			m_tready <= 1'b0;
		end else if (!hold_done && replies_seen >= HOLD_AFTER) begin
			hold_cnt = HOLD_CYCLES;
			hold_done = 1'b1;
			m_tready <= 1'b0;
		end else begin
			if (pace_left == 0) begin
				pace_mode = pace_t'($urandom_range(0, 2));
				pace_left = $urandom_range(10, 150);
			end else begin
				pace_left--;
			end
			case (pace_mode)
				PACE_OPEN:  m_tready <= 1'b1;
				PACE_LIGHT: m_tready <= ($urandom_range(0, 3) != 0);
				default:    m_tready <= ($urandom_range(0, 2) == 0);
			endcase
		end
	end

	// every reply transaction is held against the oldest prediction
	always @(posedge clk) begin : reply_check
		pasv_reply_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = pasv_reply_t'(m_tdata[28:0]);
			replies_seen++;
			if (pending_replies.size() == 0) begin
				mismatch_cnt++;
				if (mismatch_cnt <= MAX_REPORTS)
					$display("reply %0d arrived with none expected: %h", replies_seen, m_tdata);
			end else begin
				want = pending_replies.pop_front();
				if (want.port_found) ports_seen++;
				if (want.is_passive) passive_seen++;
				check_field("code_valid", 16'(want.code_valid), 16'(got.code_valid));
				check_field("reply_code", 16'(want.reply_code), 16'(got.reply_code));
				check_field("is_passive", 16'(want.is_passive), 16'(got.is_passive));
				check_field("port_found", 16'(want.port_found), 16'(got.port_found));
				check_field("data_port", want.data_port, got.data_port);
			end
		end
	end

	always @(posedge clk) begin : watchdog
		cycle_cnt++;
		if (cycle_cnt > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d replies outstanding", cycle_cnt,
				pending_replies.size());
			$display("tb failed");
			$finish;
		end
	end

	initial begin : stimulus
		string       lead_texts [5];
		logic [7:0]  blank_set [6];
		int unsigned random_bytes, line_no, kind, n_nums, n_dig;
		lead_texts = '{"Entering Passive Mode (", "(", "=", "", "v2 "};
		blank_set = '{CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR};
		clear_line_model();

		// plain passive reply, port 19*256+137
		put_text("227 Entering Passive Mode (192,168,1,2,19,137).");
		end_line(1'b0);
		// whitespace and signs before numbers, negative fifth, sixth wraps, ends at line end
		put_text("227 =1, +2,");
		put_byte(CH_TAB);
		put_text("-3,");
		put_byte(CH_CR);
		put_text("4,-1,  +300");
		end_line(1'b0);
		// large numbers wrap modulo 256
		put_text("227 1,2,3,4,1000,70000.");
		end_line(1'b0);
		// more than six numbers, the earliest attempt wins
		put_text("227 1,2,3,4,5,6,7,8");
		end_line(1'b0);
		// blank after a sign kills the early attempts, a later one succeeds
		put_text("227 1,2,+ 3,4,5,6,7,8,9");
		end_line(1'b0);
		// zero byte in the middle ends the scan
		put_text("227 1,2,");
		put_byte(CH_NUL);
		put_text("3,4,5,6");
		end_line(1'b0);
		// zero byte right after the sixth number completes the match
		put_text("227 1,2,3,4,5,6");
		put_byte(CH_NUL);
		put_text("9");
		end_line(1'b0);
		// short lines
		put_text("227");
		end_line(1'b0);
		put_text("22");
		end_line(1'b0);
		put_text("7");
		end_line(1'b0);
		put_text("227 ");
		end_line(1'b0);
		put_text("2271,2,3,4,5,6");
		end_line(1'b0);
		// bad or other codes
		put_text("2a7 1,2,3,4,5,6");
		end_line(1'b0);
		put_text("999 1,2,3,4,5,6");
		end_line(1'b0);
		put_text("000");
		put_byte(8'hFF);
		end_line(1'b0);
		put_byte(8'hFF);
		put_byte(CH_NUL);
		put_text("1");
		end_line(1'b0);
		// zero byte before the text starts is not a terminator
		put_text("227");
		put_byte(CH_NUL);
		put_text("1,2,3,4,5,6");
		end_line(1'b0);
		// port extremes
		put_text("227 0,0,0,0,255,255");
		end_line(1'b0);
		put_text("227 9,9,9,9,-1,-0)");
		end_line(1'b0);
		// attempt dies, a later run of digits carries the match
		put_text("227 1,2,3,4,5.6,7,8,9,10,11");
		end_line(1'b0);
		// line feed, vertical tab and form feed as separators; double sign fails
		put_text("227 1,");
		put_byte(CH_LF);
		put_byte(CH_VT);
		put_byte(CH_FF);
		put_text("-2,3,4,5,6");
		end_line(1'b0);
		put_text("227 1,2,3,4,-+5,6");
		end_line(1'b0);

		// random lines, mostly passive replies with six numbers and random content
		random_bytes = 0;
		line_no = 0;
		while (random_bytes < RANDOM_BYTES) begin
			kind = $urandom_range(0, 99);
			if (kind < 65) begin
				put_text("227");
				if ($urandom_range(0, 5) == 0) put_byte(8'($urandom_range(0, 255)));
				else put_byte(CH_SPACE);
				put_text(lead_texts[$urandom_range(0, 4)]);
				n_nums = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 8) : 6;
				for (int n = 0; n < n_nums; n++) begin
					if (n > 0) begin
						if ($urandom_range(0, 19) == 0) put_byte(rand_text_byte());
						else put_byte(CH_COMMA);
						if ($urandom_range(0, 3) == 0)
							repeat ($urandom_range(1, 2)) put_byte(blank_set[$urandom_range(0, 5)]);
						if ($urandom_range(0, 3) == 0) begin
							put_byte(($urandom_range(0, 1) != 0) ? CH_MINUS : CH_PLUS);
							if ($urandom_range(0, 24) == 0) put_byte(rand_text_byte());
						end
					end
					n_dig = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 6) : $urandom_range(1, 3);
					repeat (n_dig) put_byte(CH_ZERO + 8'($urandom_range(0, 9)));
				end
				case ($urandom_range(0, 5))
					0: ;
					1: put_text(")");
					2: put_text(").");
					3: begin
						put_byte(CH_NUL);
						put_byte(rand_text_byte());
					end
					4: put_text(",77");
					default: put_byte(rand_text_byte());
				endcase
			end else if (kind < 82) begin
				if ($urandom_range(0, 2) == 0) put_text("227");
				else repeat (3) put_byte(CH_ZERO + 8'($urandom_range(0, 9)));
				repeat ($urandom_range(0, 10)) put_byte(rand_text_byte());
			end else begin
				repeat ($urandom_range(1, 10)) put_byte(rand_text_byte());
			end
			random_bytes += line_buf.size();
			end_line(line_no == 0 || line_no == DRAIN_LINE);
			line_no++;
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		while (bytes_taken < bytes_total) @(posedge clk);
		while (pending_replies.size() > 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d line bytes sent, %0d reply lines checked", bytes_total, replies_seen);
		$display("%0d passive replies, %0d with a data port, %0d mismatches", passive_seen,
			ports_seen, mismatch_cnt);
		if (mismatch_cnt == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end

endmodule
